// ----- rtl/core/gga_pkg.sv -----
// shared widths, register indexes, reset values and multiplier request layout for the gated armor assignment block
package gga_pkg;

  localparam int SLOTS     = 4;
  localparam int SLOT_W    = 2;
  localparam int POS_W     = 16;
  localparam int YAW_W     = 16;
  localparam int DIFF_W    = POS_W + 1;
  localparam int SQ_W      = 32;
  localparam int DIST2_W   = SQ_W + 2;
  localparam int OBS_OUT_W = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MAX_DIST = 2'd0;
  localparam cfg_idx_t CFG_MAX_YAW  = 2'd1;

  localparam logic [15:0] MAX_DIST_RST = 16'd500;
  localparam logic [15:0] MAX_YAW_RST  = 16'd5461;

  typedef logic [1:0] axis_t;

  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  typedef struct packed {
    logic                     en;
    logic signed [DIFF_W-1:0] opa;
    logic signed [DIFF_W-1:0] opb;
  } mul_req_t;

endpackage

// ----- rtl/core/gga_ram.sv -----
// generic simple dual port ram with registered read
module gga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/gga_mul.sv -----
// shared signed multiplier with registered product, used for squares and the gate limit
module gga_mul (
  input  logic              clk,
  input  gga_pkg::mul_req_t req,
  output logic [gga_pkg::SQ_W-1:0] prod
);

  logic signed [2*gga_pkg::DIFF_W-1:0] full;
  logic [gga_pkg::SQ_W-1:0]            prod_r;

  assign full = req.opa * req.opb;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= full[gga_pkg::SQ_W-1:0];
    end
  end

  assign prod = prod_r;

endmodule

// ----- rtl/core/gated_greedy_armor_assignment.sv -----
// top level: slot store, gating sequencer, candidate memory and greedy selection passes
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | mode, slot, pos_x/y/z, heading, frame_end
//   out_    | output    | out_valid/out_stall | valid_res, obs_index, slot_index, last
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a slot load is written straight into the slot store; an observation runs the limit square, then
// three difference/square/accumulate steps and one check per slot on the one multiplier
// frame close runs one pass over the candidate memory per match plus a closing pass,
// at most five passes, and loads each result into the output register
// synchronous active low reset; no clearing pass, the candidate memory is read only
// below the fill count; out_stall holds the sequencer only when a result is pending
module gated_greedy_armor_assignment #(
  parameter int MAX_OBS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [gga_pkg::SLOT_W-1:0]      in_slot,
  input  logic signed [gga_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [gga_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [gga_pkg::POS_W-1:0] in_pos_z,
  input  logic [gga_pkg::YAW_W-1:0]       in_heading,
  input  logic                            in_frame_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_valid_res,
  output logic [gga_pkg::OBS_OUT_W-1:0]   out_obs_index,
  output logic [gga_pkg::SLOT_W-1:0]      out_slot_index,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  gga_pkg::cfg_idx_t               cfg_index,
  input  logic [15:0]                     cfg_data
);

  localparam int IDX_W    = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
  localparam int OCNT_W   = $clog2(MAX_OBS + 1);
  localparam int DEPTH    = MAX_OBS * gga_pkg::SLOTS;
  localparam int AW       = $clog2(DEPTH);
  localparam int CCNT_W   = $clog2(DEPTH + 1);
  localparam int OBS_SPAN = 1 << IDX_W;
  localparam int ENT_W    = gga_pkg::DIST2_W + gga_pkg::YAW_W + IDX_W + gga_pkg::SLOT_W;
  localparam int S_LO     = 0;
  localparam int O_LO     = gga_pkg::SLOT_W;
  localparam int Y_LO     = O_LO + IDX_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LIM  = 9'b000000010,
    ST_LIMW = 9'b000000100,
    ST_DIFF = 9'b000001000,
    ST_MUL  = 9'b000010000,
    ST_ACC  = 9'b000100000,
    ST_CHK  = 9'b001000000,
    ST_SCAN = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  typedef logic signed [gga_pkg::POS_W-1:0] pos_t;

  state_t state_r, state_nxt;

  logic [15:0] max_dist_r;
  logic [15:0] max_yaw_r;

  pos_t                      pred_x_r [gga_pkg::SLOTS];
  pos_t                      pred_y_r [gga_pkg::SLOTS];
  pos_t                      pred_z_r [gga_pkg::SLOTS];
  logic [gga_pkg::YAW_W-1:0] pred_h_r [gga_pkg::SLOTS];

  pos_t                      ob_x_r, ob_y_r, ob_z_r;
  logic [gga_pkg::YAW_W-1:0] ob_h_r;
  logic                      fe_r;

  logic [OCNT_W-1:0]         obs_cnt_r;
  logic [CCNT_W-1:0]         cand_cnt_r;
  logic [gga_pkg::SLOTS-1:0] slot_used_r;
  logic [OBS_SPAN-1:0]       obs_used_r;

  logic [gga_pkg::SQ_W-1:0]          lim_r;
  logic signed [gga_pkg::DIFF_W-1:0] diff_r;
  logic [gga_pkg::DIST2_W-1:0]       acc_r;
  logic [gga_pkg::YAW_W-1:0]         gap_r;
  logic [gga_pkg::SLOT_W-1:0]        slot_r;
  gga_pkg::axis_t                    axis_r;

  logic [CCNT_W-1:0] rd_addr_r;
  logic              dv_r;
  logic [ENT_W-1:0]  best_r;
  logic              best_vld_r;
  logic [ENT_W-1:0]  pend_r;
  logic              pend_vld_r;

  logic                          em_valid_res_r;
  logic [IDX_W-1:0]              em_obs_r;
  logic [gga_pkg::SLOT_W-1:0]    em_slot_r;
  logic                          em_last_r;

  logic                            out_valid_r;
  logic                            out_valid_res_r;
  logic [gga_pkg::OBS_OUT_W-1:0]   out_obs_r;
  logic [gga_pkg::SLOT_W-1:0]      out_slot_r;
  logic                            out_last_r;

  logic                      in_acc;
  gga_pkg::mul_req_t         mreq;
  logic [gga_pkg::SQ_W-1:0]  prod;
  logic                      wr_en;
  logic [ENT_W-1:0]          wr_data;
  logic                      rd_en;
  logic [ENT_W-1:0]          rd_data;
  logic signed [gga_pkg::DIFF_W-1:0] diff_nxt;
  logic [gga_pkg::YAW_W-1:0] yaw_d;
  logic [gga_pkg::YAW_W-1:0] gap_nxt;
  logic                      pass_ok;
  logic                      cand_skip;
  logic                      cand_take;
  logic                      pass_end;
  logic                      out_free;
  logic                      last_slot;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_slot = (slot_r == gga_pkg::SLOT_W'(gga_pkg::SLOTS - 1));

  // difference of one axis against the current slot
  always_comb begin
    case (axis_r)
      gga_pkg::AX_X: diff_nxt = gga_pkg::DIFF_W'(ob_x_r) - gga_pkg::DIFF_W'(pred_x_r[slot_r]);
      gga_pkg::AX_Y: diff_nxt = gga_pkg::DIFF_W'(ob_y_r) - gga_pkg::DIFF_W'(pred_y_r[slot_r]);
      default:       diff_nxt = gga_pkg::DIFF_W'(ob_z_r) - gga_pkg::DIFF_W'(pred_z_r[slot_r]);
    endcase
  end

  // wrapped yaw difference, half turn stays 32768
  assign yaw_d   = ob_h_r - pred_h_r[slot_r];
  assign gap_nxt = yaw_d[gga_pkg::YAW_W-1] ? (gga_pkg::YAW_W'(0) - yaw_d) : yaw_d;

  assign pass_ok = (acc_r <= gga_pkg::DIST2_W'(lim_r)) && (gap_r <= max_yaw_r)
                   && (cand_cnt_r < CCNT_W'(DEPTH));

  always_comb begin
    mreq.en  = (state_r == ST_LIM) || (state_r == ST_MUL);
    mreq.opa = (state_r == ST_LIM) ? $signed({1'b0, max_dist_r}) : diff_r;
    mreq.opb = mreq.opa;
  end

  gga_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  assign wr_en   = (state_r == ST_CHK) && pass_ok;
  assign wr_data = {acc_r, gap_r, obs_cnt_r[IDX_W-1:0], slot_r};
  assign rd_en   = (state_r == ST_SCAN) && (rd_addr_r < cand_cnt_r);

  gga_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_cand_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cand_cnt_r[AW-1:0]),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign cand_skip = slot_used_r[rd_data[O_LO-1:S_LO]] || obs_used_r[rd_data[Y_LO-1:O_LO]];
  assign cand_take = dv_r && !cand_skip && (!best_vld_r || (rd_data < best_r));
  assign pass_end  = (state_r == ST_SCAN) && !rd_en && !dv_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode) begin
          if (obs_cnt_r < OCNT_W'(MAX_OBS)) begin
            state_nxt = ST_LIM;
          end else if (in_frame_end) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LIM:  state_nxt = ST_LIMW;
      ST_LIMW: state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (axis_r == gga_pkg::AX_Z) ? ST_CHK : ST_DIFF;
      ST_CHK: begin
        if (!last_slot) begin
          state_nxt = ST_DIFF;
        end else begin
          state_nxt = fe_r ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (pass_end && (!best_vld_r || pend_vld_r)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = em_last_r ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_dist_r  <= gga_pkg::MAX_DIST_RST;
      max_yaw_r   <= gga_pkg::MAX_YAW_RST;
      obs_cnt_r   <= '0;
      cand_cnt_r  <= '0;
      slot_used_r <= '0;
      obs_used_r  <= '0;
      rd_addr_r   <= '0;
      dv_r        <= 1'b0;
      best_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < gga_pkg::SLOTS; i++) begin
        pred_x_r[i] <= '0;
        pred_y_r[i] <= '0;
        pred_z_r[i] <= '0;
        pred_h_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gga_pkg::CFG_MAX_DIST: max_dist_r <= cfg_data;
          gga_pkg::CFG_MAX_YAW:  max_yaw_r  <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc && !in_mode) begin
        pred_x_r[in_slot] <= in_pos_x;
        pred_y_r[in_slot] <= in_pos_y;
        pred_z_r[in_slot] <= in_pos_z;
        pred_h_r[in_slot] <= in_heading;
      end

      if (wr_en) begin
        cand_cnt_r <= cand_cnt_r + CCNT_W'(1);
      end
      if ((state_r == ST_CHK) && last_slot) begin
        obs_cnt_r <= obs_cnt_r + OCNT_W'(1);
      end

      // selection passes
      dv_r <= rd_en;
      if (rd_en) begin
        rd_addr_r <= rd_addr_r + CCNT_W'(1);
      end
      if (cand_take) begin
        best_r     <= rd_data;
        best_vld_r <= 1'b1;
      end
      if (pass_end) begin
        rd_addr_r  <= '0;
        best_vld_r <= 1'b0;
        if (best_vld_r) begin
          slot_used_r[best_r[O_LO-1:S_LO]] <= 1'b1;
          obs_used_r[best_r[Y_LO-1:O_LO]]  <= 1'b1;
          pend_r     <= best_r;
          pend_vld_r <= 1'b1;
        end
      end

      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
        if (em_last_r) begin
          obs_cnt_r   <= '0;
          cand_cnt_r  <= '0;
          slot_used_r <= '0;
          obs_used_r  <= '0;
          pend_vld_r  <= 1'b0;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && in_mode) begin
      ob_x_r <= in_pos_x;
      ob_y_r <= in_pos_y;
      ob_z_r <= in_pos_z;
      ob_h_r <= in_heading;
      fe_r   <= in_frame_end;
    end
    case (state_r)
      ST_LIMW: begin
        lim_r  <= prod;
        acc_r  <= '0;
        slot_r <= '0;
        axis_r <= gga_pkg::AX_X;
      end
      ST_DIFF: diff_r <= diff_nxt;
      ST_MUL:  gap_r  <= gap_nxt;
      ST_ACC: begin
        acc_r <= acc_r + gga_pkg::DIST2_W'(prod);
        if (axis_r != gga_pkg::AX_Z) begin
          axis_r <= axis_r + gga_pkg::axis_t'(1);
        end
      end
      ST_CHK: begin
        acc_r  <= '0;
        axis_r <= gga_pkg::AX_X;
        slot_r <= slot_r + gga_pkg::SLOT_W'(1);
      end
      default: ;
    endcase

    // result held from the pass before waits here for the output register
    if (pass_end) begin
      if (best_vld_r) begin
        em_valid_res_r <= 1'b1;
        em_obs_r       <= pend_r[Y_LO-1:O_LO];
        em_slot_r      <= pend_r[O_LO-1:S_LO];
        em_last_r      <= 1'b0;
      end else if (pend_vld_r) begin
        em_valid_res_r <= 1'b1;
        em_obs_r       <= pend_r[Y_LO-1:O_LO];
        em_slot_r      <= pend_r[O_LO-1:S_LO];
        em_last_r      <= 1'b1;
      end else begin
        em_valid_res_r <= 1'b0;
        em_obs_r       <= '0;
        em_slot_r      <= '0;
        em_last_r      <= 1'b1;
      end
    end

    if ((state_r == ST_EMIT) && out_free) begin
      out_valid_res_r <= em_valid_res_r;
      out_obs_r       <= gga_pkg::OBS_OUT_W'(em_obs_r);
      out_slot_r      <= em_slot_r;
      out_last_r      <= em_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = out_valid_res_r;
  assign out_obs_index  = out_obs_r;
  assign out_slot_index = out_slot_r;
  assign out_last       = out_last_r;

endmodule

// ----- sim/gga_assign_checker.sv -----
// checker for the gated armor assignment block: watches all channels, predicts and compares
module gga_assign_checker
  import gga_pkg::*;
#(
  parameter int MAX_OBS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_mode,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [YAW_W-1:0]        in_heading,
  input  logic                    in_frame_end,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_valid_res,
  input  logic [OBS_OUT_W-1:0]    out_obs_index,
  input  logic [SLOT_W-1:0]       out_slot_index,
  input  logic                    out_last,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  cfg_idx_t                cfg_index,
  input  logic [15:0]             cfg_data,
  output int                      mismatches,
  output int                      matches_owed
);

  typedef struct packed {
    logic                 valid_res;
    logic [OBS_OUT_W-1:0] obs;
    logic [SLOT_W-1:0]    slot;
    logic                 last;
  } match_t;

  typedef struct {
    logic [DIST2_W-1:0] dist2;
    logic [16:0]        yaw_gap;
    int                 obs;
    int                 slot;
  } pair_t;

  logic [15:0]             gate_dist;
  logic [15:0]             gate_yaw;
  logic signed [POS_W-1:0] slot_x [SLOTS];
  logic signed [POS_W-1:0] slot_y [SLOTS];
  logic signed [POS_W-1:0] slot_z [SLOTS];
  logic [YAW_W-1:0]        slot_h [SLOTS];
  pair_t                   gated_pairs [$];
  int                      obs_seen;
  match_t                  owed_q [$];

  initial begin
    gate_dist = MAX_DIST_RST;
    gate_yaw = MAX_YAW_RST;
    foreach (slot_x[s]) begin
      slot_x[s] = '0;
      slot_y[s] = '0;
      slot_z[s] = '0;
      slot_h[s] = '0;
    end
    obs_seen = 0;
    mismatches = 0;
    matches_owed = 0;
  end

  task automatic report(input string msg);
    $display("gga_check t=%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [DIST2_W-1:0] axis_sq(input logic signed [POS_W-1:0] a,
                                                 input logic signed [POS_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] m;
    d = a - b;
    m = d[DIFF_W-1] ? DIFF_W'(-d) : d;
    return DIST2_W'(m) * DIST2_W'(m);
  endfunction

  function automatic bit ranks_ahead(input pair_t a, input pair_t b);
    if (a.dist2 != b.dist2) return a.dist2 < b.dist2;
    if (a.yaw_gap != b.yaw_gap) return a.yaw_gap < b.yaw_gap;
    if (a.obs != b.obs) return a.obs < b.obs;
    return a.slot < b.slot;
  endfunction

  task automatic gate_against_slots();
    logic [DIST2_W-1:0] d2;
    logic [DIST2_W-1:0] lim;
    logic [15:0] dy;
    logic [16:0] gap;
    pair_t p;
    lim = DIST2_W'(gate_dist) * DIST2_W'(gate_dist);
    for (int s = 0; s < SLOTS; s++) begin
      d2 = axis_sq(in_pos_x, slot_x[s]) + axis_sq(in_pos_y, slot_y[s])
         + axis_sq(in_pos_z, slot_z[s]);
      dy = in_heading - slot_h[s];
      gap = dy[15] ? 17'h10000 - {1'b0, dy} : {1'b0, dy};
      if (d2 <= lim && gap <= {1'b0, gate_yaw} && gated_pairs.size() < MAX_OBS * SLOTS) begin
        p.dist2 = d2;
        p.yaw_gap = gap;
        p.obs = obs_seen;
        p.slot = s;
        gated_pairs.push_back(p);
      end
    end
    obs_seen++;
  endtask

  task automatic pick_greedy_matches();
    logic [SLOTS-1:0] slot_taken;
    logic [63:0] obs_taken;
    match_t found [$];
    match_t m;
    int best;
    slot_taken = '0;
    obs_taken = '0;
    forever begin
      best = -1;
      foreach (gated_pairs[i]) begin
        if (slot_taken[gated_pairs[i].slot] || obs_taken[gated_pairs[i].obs]) continue;
        if (best < 0 || ranks_ahead(gated_pairs[i], gated_pairs[best])) best = i;
      end
      if (best < 0 || found.size() >= SLOTS) break;
      slot_taken[gated_pairs[best].slot] = 1'b1;
      obs_taken[gated_pairs[best].obs] = 1'b1;
      m.valid_res = 1'b1;
      m.obs = OBS_OUT_W'(gated_pairs[best].obs);
      m.slot = SLOT_W'(gated_pairs[best].slot);
      m.last = 1'b0;
      found.push_back(m);
    end
    if (found.size() == 0) begin
      m = '0;
      m.last = 1'b1;
      found.push_back(m);
    end else begin
      found[found.size()-1].last = 1'b1;
    end
    foreach (found[i]) owed_q.push_back(found[i]);
    gated_pairs.delete();
    obs_seen = 0;
  endtask

  always @(posedge clk) begin
    match_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_DIST: gate_dist = cfg_data;
          CFG_MAX_YAW:  gate_yaw = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (!in_mode) begin
          slot_x[in_slot] = in_pos_x;
          slot_y[in_slot] = in_pos_y;
          slot_z[in_slot] = in_pos_z;
          slot_h[in_slot] = in_heading;
        end else begin
          if (obs_seen < MAX_OBS) gate_against_slots();
          if (in_frame_end) pick_greedy_matches();
        end
      end
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          report($sformatf("unexpected result valid_res %0d obs %0d slot %0d last %0d",
                           out_valid_res, out_obs_index, out_slot_index, out_last));
        end else begin
          want = owed_q.pop_front();
          if (out_valid_res !== want.valid_res)
            report($sformatf("valid_res got %0d want %0d", out_valid_res, want.valid_res));
          if (out_obs_index !== want.obs)
            report($sformatf("obs_index got %0d want %0d", out_obs_index, want.obs));
          if (out_slot_index !== want.slot)
            report($sformatf("slot_index got %0d want %0d", out_slot_index, want.slot));
          if (out_last !== want.last)
            report($sformatf("last got %0d want %0d", out_last, want.last));
        end
      end
      matches_owed = owed_q.size();
    end
  end

endmodule

// ----- sim/gated_greedy_armor_assignment_tb.sv -----
// testbench top for the gated armor assignment block: clock, reset, requests and verdict
module gated_greedy_armor_assignment_tb;
  import gga_pkg::*;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_OBS  = 1'b1;
  localparam int   SETTLE    = 500;
  localparam int   LIMIT     = 600000;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_mode;
  logic [SLOT_W-1:0]       in_slot;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic signed [POS_W-1:0] in_pos_z;
  logic [YAW_W-1:0]        in_heading;
  logic                    in_frame_end;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_valid_res;
  logic [OBS_OUT_W-1:0]    out_obs_index;
  logic [SLOT_W-1:0]       out_slot_index;
  logic                    out_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  cfg_idx_t                cfg_index;
  logic [15:0]             cfg_data;

  int                      fail_count;
  int                      owed;
  int                      cycles = 0;
  int                      sent = 0;
  int                      cur_dist;
  int                      cur_yaw;
  bit                      tx_calm = 1'b0;
  bit                      rx_calm = 1'b0;
  logic                    rx_took = 1'b0;
  int                      rx_wait = 0;
  logic signed [POS_W-1:0] aim_x [SLOTS];
  logic signed [POS_W-1:0] aim_y [SLOTS];
  logic signed [POS_W-1:0] aim_z [SLOTS];
  logic [YAW_W-1:0]        aim_h [SLOTS];

  always #5 clk = ~clk;

  gated_greedy_armor_assignment DUT (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_slot, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_heading, .in_frame_end,
    .out_valid, .out_stall, .out_valid_res, .out_obs_index, .out_slot_index, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gga_assign_checker u_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_slot, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_heading, .in_frame_end,
    .out_valid, .out_stall, .out_valid_res, .out_obs_index, .out_slot_index, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches(fail_count),
    .matches_owed(owed)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("gated_greedy_armor_assignment_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) rx_took <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (rx_took) begin
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 17);
    end
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [15:0] jitter(input int r);
    int v;
    v = int'($urandom_range(0, 2 * r)) - r;
    return v[15:0];
  endfunction

  task automatic send(input logic mode, input logic [SLOT_W-1:0] slot,
                      input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                      input logic [15:0] h, input logic fe);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode <= mode;
    in_slot <= slot;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_heading <= h;
    in_frame_end <= fe;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (mode == MODE_LOAD) begin
      aim_x[slot] = x;
      aim_y[slot] = y;
      aim_z[slot] = z;
      aim_h[slot] = h;
    end
    sent++;
  endtask

  task automatic observe_near(input int s, input logic fe);
    int r;
    int yr;
    r = cur_dist / 2 + 2;
    yr = cur_yaw + 2;
    if ($urandom_range(0, 2) == 0)
      send(MODE_OBS, 2'($urandom_range(0, 3)), aim_x[s], aim_y[s], aim_z[s], aim_h[s], fe);
    else
      send(MODE_OBS, 2'($urandom_range(0, 3)), aim_x[s] + jitter(r), aim_y[s] + jitter(r),
           aim_z[s] + jitter(r), aim_h[s] + jitter(yr), fe);
  endtask

  // hold requests until every owed result has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] data);
    settle();
    repeat (SETTLE) @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_DIST: cur_dist = int'(data);
      CFG_MAX_YAW:  cur_yaw = int'(data);
      default: ;
    endcase
  endtask

  task automatic random_frames(input int count);
    int stop;
    int kind;
    int n;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic [15:0] ch;
    stop = sent + count;
    while (sent < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        n = $urandom_range(1, 4);
        repeat (n)
          send(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      end else if (kind < 15) begin
        n = $urandom_range(17, 20);
        for (int k = 1; k <= n; k++) observe_near($urandom_range(0, 3), k == n);
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          cx = 16'($urandom);
          cy = 16'($urandom);
          cz = 16'($urandom);
          ch = 16'($urandom);
          for (int s = 0; s < SLOTS; s++)
            if ($urandom_range(0, 3) != 0)
              send(MODE_LOAD, 2'(s), cx + jitter(cur_dist), cy + jitter(cur_dist),
                   cz + jitter(cur_dist), ch + jitter(cur_yaw + 2),
                   1'($urandom_range(0, 1)));
        end
        n = $urandom_range(1, 6);
        for (int k = 1; k <= n; k++) begin
          if ($urandom_range(0, 9) == 0)
            send(MODE_LOAD, 2'($urandom_range(0, 3)), aim_x[0] + jitter(cur_dist),
                 aim_y[0] + jitter(cur_dist), aim_z[0] + jitter(cur_dist),
                 aim_h[0] + jitter(cur_yaw + 2), 1'($urandom_range(0, 1)));
          observe_near($urandom_range(0, 3), k == n);
        end
      end
    end
  endtask

  task automatic run_phase(input int count);
    random_frames(count / 2);
    settle();
    random_frames(count - count / 2);
    send(MODE_OBS, 2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom), 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_LOAD;
    in_slot = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_heading = '0;
    in_frame_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_DIST;
    cfg_data = '0;
    cur_dist = int'(MAX_DIST_RST);
    cur_yaw = int'(MAX_YAW_RST);
    foreach (aim_x[s]) begin
      aim_x[s] = '0;
      aim_y[s] = '0;
      aim_z[s] = '0;
      aim_h[s] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // slot loads at the field extremes, frame end on a load does nothing
    send(MODE_LOAD, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1);
    send(MODE_LOAD, 2'd1, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 1'b0);
    send(MODE_LOAD, 2'd2, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send(MODE_LOAD, 2'd3, 16'd1000, -16'sd1000, 16'd300, 16'd16384, 1'b0);
    // exact hits, gate edges and a tie broken by observation order
    send(MODE_OBS, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'hffff, 1'b0);
    send(MODE_OBS, 2'd3, 16'd1000, -16'sd1000, 16'd800, 16'd21845, 1'b0);
    send(MODE_OBS, 2'd2, 16'sd0, 16'sd0, 16'sd0, 16'hffff, 1'b0);
    send(MODE_OBS, 2'd1, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 1'b1);
    // nothing inside the gate
    send(MODE_OBS, 2'd0, 16'sd0, 16'sd0, 16'sd501, 16'd0, 1'b1);
    // yaw just outside, wrapped yaw on the edge, then a slot reload mid frame
    send(MODE_OBS, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'd5462, 1'b0);
    send(MODE_OBS, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'd60075, 1'b0);
    send(MODE_LOAD, 2'd0, 16'sd100, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send(MODE_OBS, 2'd0, 16'sd100, 16'sd0, 16'sd0, 16'd0, 1'b1);
    send(MODE_OBS, 2'd3, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    run_phase(80);

    cfg_write(CFG_MAX_DIST, 16'hffff);
    cfg_write(CFG_MAX_YAW, 16'h8000);
    // half turn apart and the widest position difference
    send(MODE_LOAD, 2'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
    send(MODE_OBS, 2'd1, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 1'b1);
    send(MODE_LOAD, 2'd1, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 1'b0);
    send(MODE_OBS, 2'd2, 16'h8000, 16'h8000, 16'h8000, 16'd0, 1'b1);
    run_phase(80);

    cfg_write(CFG_MAX_DIST, 16'd0);
    cfg_write(CFG_MAX_YAW, 16'd0);
    run_phase(80);

    cfg_write(CFG_MAX_DIST, 16'($urandom_range(20, 4000)));
    cfg_write(CFG_MAX_YAW, 16'($urandom_range(0, 32768)));
    run_phase(80);

    cfg_write(CFG_MAX_YAW, 16'($urandom_range(0, 32768)));
    cfg_write(CFG_MAX_DIST, 16'($urandom_range(1, 65535)));
    run_phase(80);

    settle();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0)
      $display("gated_greedy_armor_assignment_tb: done, clean");
    else
      $display("gated_greedy_armor_assignment_tb: done, errors");
    $finish;
  end

endmodule
